// ----- rtl/sptg_pkg.sv -----
// Shared types and constants for the pulse train stimulus generator.
// No dependencies; imported by every RTL module of the block except sptg_checker.
package sptg_pkg;

  localparam int SAMPLE_BITS = 32;

  typedef enum logic [1:0] {
    PTYPE_TTL      = 2'd0,
    PTYPE_SQUARE   = 2'd1,
    PTYPE_BIPHASIC = 2'd2,
    PTYPE_RAMP     = 2'd3
  } ptype_t;

  typedef enum logic [2:0] {
    REG_START_DELAY  = 3'd0,
    REG_TRAIN_PERIOD = 3'd1,
    REG_PULSE_PERIOD = 3'd2,
    REG_FIRST_LEN    = 3'd3,
    REG_SECOND_LEN   = 3'd4,
    REG_FIRST_LEVEL  = 3'd5,
    REG_SECOND_LEVEL = 3'd6,
    REG_TRAIN_CTRL   = 3'd7
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_T,
    ST_MUL_P,
    ST_END,
    ST_TRAIN,
    ST_CMP,
    ST_DIV,
    ST_EVAL,
    ST_NEXT,
    ST_RMUL,
    ST_RINIT,
    ST_RDIV,
    ST_RFIN,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic mul_t;
    logic mul_p;
    logic end_calc;
    logic train_sub;
    logic cmp;
    logic div_step;
    logic eval;
    logic next_train;
    logic rmul;
    logic rinit;
    logic rdiv_step;
    logic rfin;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic t_ge_s;
    logic d_ge_m;
    logic div_last;
    logic last_train;
    logic found;
    logic is_ramp;
    logic rdiv_last;
    logic out_free;
  } status_t;

endpackage

// ----- rtl/stimulus_pulse_train_generator.sv -----
// Top level of the pulse train stimulus generator: APB register file plus
// sptg_ctrl and sptg_dp. Depends on sptg_pkg.
//
// Use: each transfer on the in_ channel is one sample tick; in_restart = 1
// returns the sample counter to zero before that sample is worked out. Each
// tick gives exactly one transfer on the out_ channel carrying the level, the
// first-phase digital bit, the pulse and train window flags and the done flag.
// Timing registers are in samples and are written over the cfg_ APB port;
// the user must write them only while the block is idle; the block itself
// does not enforce this. Per tick the sequencer forms the train and pulse
// products and the end test, then visits each train (if it has started:
// subtract, compare, remainder division unless at or past the last pulse
// start, evaluate), then divides out a ramp level. The trains are visited
// one at a time by a shared remainder unit (one quotient bit a cycle); the
// ramp value comes from a restoring divider (one bit a cycle). One tick is
// in flight at a time; in_ready is high only while the sequencer is idle.
// The result sits in an output register, so the next tick is taken while an
// unread result waits; a stalled receiver holds the sequencer at its final
// step. Reset clears the sample counter, the config registers and out_valid.
module stimulus_pulse_train_generator #(
  parameter int TIME_BITS  = 24,
  parameter int LEVEL_BITS = 16,
  parameter int COUNT_BITS = 8,
  localparam int CTRL_W = 2 * COUNT_BITS + 2,
  localparam int DATA_W = (CTRL_W > 32) ? 64 : 32,
  localparam int ALSB   = (DATA_W == 64) ? 3 : 2,
  localparam int AW     = ALSB + 3
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_restart,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [LEVEL_BITS-1:0] out_level,
  output logic                         out_digital_out,
  output logic                         out_pulse_window,
  output logic                         out_train_window,
  output logic                         out_all_done,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [AW-1:0]                cfg_paddr,
  input  logic [DATA_W-1:0]            cfg_pwdata,
  output logic [DATA_W-1:0]            cfg_prdata,
  output logic                         cfg_pready
);
  import sptg_pkg::*;

  logic [TIME_BITS-1:0]         start_delay_r, train_period_r, pulse_period_r;
  logic [TIME_BITS-1:0]         first_len_r, second_len_r;
  logic signed [LEVEL_BITS-1:0] first_level_r, second_level_r;
  logic [CTRL_W-1:0]            train_ctrl_r;
  reg_idx_t                     widx;
  logic                         wr_en;
  cmd_t                         cmd;
  status_t                      status;

  assign cfg_pready = 1'b1;
  assign widx       = reg_idx_t'(cfg_paddr[AW-1:ALSB]);
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;

  // register file: all fields reset to zero, written on the APB access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_delay_r  <= '0;
      train_period_r <= '0;
      pulse_period_r <= '0;
      first_len_r    <= '0;
      second_len_r   <= '0;
      first_level_r  <= '0;
      second_level_r <= '0;
      train_ctrl_r   <= '0;
    end else if (wr_en) begin
      unique case (widx)
        REG_START_DELAY:  start_delay_r  <= cfg_pwdata[TIME_BITS-1:0];
        REG_TRAIN_PERIOD: train_period_r <= cfg_pwdata[TIME_BITS-1:0];
        REG_PULSE_PERIOD: pulse_period_r <= cfg_pwdata[TIME_BITS-1:0];
        REG_FIRST_LEN:    first_len_r    <= cfg_pwdata[TIME_BITS-1:0];
        REG_SECOND_LEN:   second_len_r   <= cfg_pwdata[TIME_BITS-1:0];
        REG_FIRST_LEVEL:  first_level_r  <= cfg_pwdata[LEVEL_BITS-1:0];
        REG_SECOND_LEVEL: second_level_r <= cfg_pwdata[LEVEL_BITS-1:0];
        REG_TRAIN_CTRL:   train_ctrl_r   <= cfg_pwdata[CTRL_W-1:0];
        default: ;
      endcase
    end
  end

  // read back, zero extended
  always_comb begin
    unique case (widx)
      REG_START_DELAY:  cfg_prdata = DATA_W'(start_delay_r);
      REG_TRAIN_PERIOD: cfg_prdata = DATA_W'(train_period_r);
      REG_PULSE_PERIOD: cfg_prdata = DATA_W'(pulse_period_r);
      REG_FIRST_LEN:    cfg_prdata = DATA_W'(first_len_r);
      REG_SECOND_LEN:   cfg_prdata = DATA_W'(second_len_r);
      REG_FIRST_LEVEL:  cfg_prdata = DATA_W'($unsigned(first_level_r));
      REG_SECOND_LEVEL: cfg_prdata = DATA_W'($unsigned(second_level_r));
      REG_TRAIN_CTRL:   cfg_prdata = DATA_W'(train_ctrl_r);
      default:          cfg_prdata = '0;
    endcase
  end

  sptg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  sptg_dp #(
    .TIME_BITS  (TIME_BITS),
    .LEVEL_BITS (LEVEL_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .in_restart       (in_restart),
    .start_delay      (start_delay_r),
    .train_period     (train_period_r),
    .pulse_period     (pulse_period_r),
    .first_phase_len  (first_len_r),
    .second_phase_len (second_len_r),
    .first_level      (first_level_r),
    .second_level     (second_level_r),
    .npulses          (train_ctrl_r[COUNT_BITS-1:0]),
    .ntrains          (train_ctrl_r[2*COUNT_BITS-1:COUNT_BITS]),
    .ptype            (ptype_t'(train_ctrl_r[CTRL_W-1:2*COUNT_BITS])),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .out_level        (out_level),
    .out_digital_out  (out_digital_out),
    .out_pulse_window (out_pulse_window),
    .out_train_window (out_train_window),
    .out_all_done     (out_all_done)
  );

endmodule

// ----- rtl/sptg_ctrl.sv -----
// Sequencer for the pulse train generator: walks trains, divider steps, output.
// Depends on sptg_pkg; drives sptg_dp through cmd_t, reads status_t.
module sptg_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  sptg_pkg::status_t status,
  output sptg_pkg::cmd_t    cmd
);
  import sptg_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_MUL_T;
      ST_MUL_T: state_nxt = ST_MUL_P;
      ST_MUL_P: state_nxt = ST_END;
      ST_END:   state_nxt = status.empty ? ST_OUT : ST_TRAIN;
      ST_TRAIN: state_nxt = status.t_ge_s ? ST_CMP : ST_NEXT;
      ST_CMP:   state_nxt = status.d_ge_m ? ST_EVAL : ST_DIV;
      ST_DIV:   if (status.div_last) state_nxt = ST_EVAL;
      ST_EVAL:  state_nxt = ST_NEXT;
      ST_NEXT: begin
        if (!status.last_train) state_nxt = ST_TRAIN;
        else if (status.found && status.is_ramp) state_nxt = ST_RMUL;
        else state_nxt = ST_OUT;
      end
      ST_RMUL:  state_nxt = ST_RINIT;
      ST_RINIT: state_nxt = ST_RDIV;
      ST_RDIV:  if (status.rdiv_last) state_nxt = ST_RFIN;
      ST_RFIN:  state_nxt = ST_OUT;
      ST_OUT:   if (status.out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.start = in_valid;
      end
      ST_MUL_T: cmd.mul_t     = 1'b1;
      ST_MUL_P: cmd.mul_p     = 1'b1;
      ST_END:   cmd.end_calc  = 1'b1;
      ST_TRAIN: cmd.train_sub = 1'b1;
      ST_CMP:   cmd.cmp       = 1'b1;
      ST_DIV:   cmd.div_step  = 1'b1;
      ST_EVAL:  cmd.eval      = 1'b1;
      ST_NEXT:  cmd.next_train = !status.last_train;
      ST_RMUL:  cmd.rmul      = 1'b1;
      ST_RINIT: cmd.rinit     = 1'b1;
      ST_RDIV:  cmd.rdiv_step = 1'b1;
      ST_RFIN:  cmd.rfin      = 1'b1;
      ST_OUT:   cmd.load_out  = status.out_free;
      default: ;
    endcase
  end

endmodule

// ----- rtl/sptg_dp.sv -----
// Datapath: sample counter, train/pulse offset arithmetic, remainder and ramp
// dividers, output register. Depends on sptg_pkg; controlled by sptg_ctrl.
module sptg_dp #(
  parameter int TIME_BITS  = 24,
  parameter int LEVEL_BITS = 16,
  parameter int COUNT_BITS = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  sptg_pkg::cmd_t               cmd,
  output sptg_pkg::status_t            status,
  input  logic                         in_restart,
  input  logic [TIME_BITS-1:0]         start_delay,
  input  logic [TIME_BITS-1:0]         train_period,
  input  logic [TIME_BITS-1:0]         pulse_period,
  input  logic [TIME_BITS-1:0]         first_phase_len,
  input  logic [TIME_BITS-1:0]         second_phase_len,
  input  logic signed [LEVEL_BITS-1:0] first_level,
  input  logic signed [LEVEL_BITS-1:0] second_level,
  input  logic [COUNT_BITS-1:0]        npulses,
  input  logic [COUNT_BITS-1:0]        ntrains,
  input  sptg_pkg::ptype_t             ptype,
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic signed [LEVEL_BITS-1:0] out_level,
  output logic                         out_digital_out,
  output logic                         out_pulse_window,
  output logic                         out_train_window,
  output logic                         out_all_done
);
  import sptg_pkg::*;

  localparam int TW  = TIME_BITS;
  localparam int LW  = LEVEL_BITS;
  localparam int CW  = COUNT_BITS;
  localparam int XW  = (TW + CW + 3 > SAMPLE_BITS + 1) ? TW + CW + 3 : SAMPLE_BITS + 1;
  localparam int QW  = LW + 2;
  localparam int RW  = TW + LW + 2;
  localparam int DCW = $clog2(CW);
  localparam int QCW = $clog2(QW);

  logic [SAMPLE_BITS-1:0] samp_r, samp_nxt, t_cur;
  logic [XW-1:0]    t_r, mt_r, mp_r, s_r, tdur_r, d_r, off_r;
  logic [XW-1:0]    l1_x, lfull_x, lwin_x;
  logic [TW+CW-1:0] mt_prod, mp_prod, dsh_r;
  logic [CW-1:0]    ntm1, npm1, k_r;
  logic [DCW-1:0]   dcnt_r;
  logic             done_r, dig_r, pwin_r, twin_r, found_r, neg_r;
  logic [TW-1:0]    offw_r, ds;
  logic signed [LW-1:0] lvl_r;
  logic signed [LW:0]   diff;
  logic [LW:0]      mag_d;
  logic [RW-1:0]    rprod, prod_r, rrem_r, rsh_r;
  logic [QW-1:0]    q_r;
  logic [QCW-1:0]   qcnt_r;
  logic [LW+2:0]    rsum;
  logic             rge, dge, win_now;

  assign t_cur    = in_restart ? '0 : samp_r;
  assign samp_nxt = (&t_cur) ? t_cur : t_cur + 1'b1;

  assign l1_x    = XW'(first_phase_len);
  assign lfull_x = l1_x + ((ptype == PTYPE_BIPHASIC) ? XW'(second_phase_len) : '0);
  assign lwin_x  = (lfull_x == '0) ? XW'(1) : lfull_x;

  assign ntm1    = ntrains - 1'b1;
  assign npm1    = npulses - 1'b1;
  assign mt_prod = ntm1 * train_period;
  assign mp_prod = npm1 * pulse_period;

  // ramp: |b - a| * off, then (num + ds/2) / ds
  assign diff  = $signed({second_level[LW-1], second_level})
               - $signed({first_level[LW-1], first_level});
  assign mag_d = diff[LW] ? -diff : diff;
  assign ds    = (first_phase_len > TW'(2)) ? first_phase_len - 1'b1 : TW'(1);
  assign rprod = mag_d * offw_r;
  assign rge   = rrem_r >= rsh_r;
  assign rsum  = neg_r ? {{3{first_level[LW-1]}}, first_level} - {1'b0, q_r}
                       : {{3{first_level[LW-1]}}, first_level} + {1'b0, q_r};

  assign dge     = off_r >= XW'(dsh_r);
  assign win_now = !found_r && (off_r < lfull_x);

  assign status.empty      = (npulses == '0) || (ntrains == '0);
  assign status.t_ge_s     = t_r >= s_r;
  assign status.d_ge_m     = d_r >= mp_r;
  assign status.div_last   = dcnt_r == '0;
  assign status.last_train = k_r == '0;
  assign status.found      = found_r;
  assign status.is_ramp    = ptype == PTYPE_RAMP;
  assign status.rdiv_last  = qcnt_r == '0;
  assign status.out_free   = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      samp_r    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.start) samp_r <= samp_nxt;
      if (cmd.load_out) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      t_r     <= XW'(t_cur);
      k_r     <= ntm1;
      dig_r   <= 1'b0;
      pwin_r  <= 1'b0;
      twin_r  <= 1'b0;
      found_r <= 1'b0;
      lvl_r   <= '0;
    end
    if (cmd.mul_t) mt_r <= XW'(mt_prod);
    if (cmd.mul_p) begin
      mp_r <= XW'(mp_prod);
      s_r  <= XW'(start_delay) + mt_r;
    end
    if (cmd.end_calc) begin
      done_r <= status.empty || (t_r >= s_r + mp_r + lwin_x);
      tdur_r <= mp_r + lfull_x;
    end
    if (cmd.train_sub) d_r <= t_r - s_r;
    if (cmd.cmp) begin
      off_r  <= status.d_ge_m ? d_r - mp_r : d_r;
      dsh_r  <= (TW+CW)'(pulse_period) << (CW - 1);
      dcnt_r <= DCW'(CW - 1);
    end
    if (cmd.div_step) begin
      if (dge) off_r <= off_r - XW'(dsh_r);
      dsh_r  <= dsh_r >> 1;
      dcnt_r <= dcnt_r - 1'b1;
    end
    if (cmd.eval) begin
      if (d_r < tdur_r) twin_r <= 1'b1;
      if (off_r < l1_x) dig_r <= 1'b1;
      if (off_r < lwin_x) pwin_r <= 1'b1;
      if (win_now) begin
        found_r <= 1'b1;
        offw_r  <= off_r[TW-1:0];
        lvl_r   <= (off_r < l1_x) ? first_level : second_level;
      end
    end
    if (cmd.next_train) begin
      k_r <= k_r - 1'b1;
      s_r <= s_r - XW'(train_period);
    end
    if (cmd.rmul) begin
      prod_r <= rprod;
      neg_r  <= diff[LW];
    end
    if (cmd.rinit) begin
      rrem_r <= prod_r + RW'(ds >> 1);
      rsh_r  <= RW'(ds) << (QW - 1);
      qcnt_r <= QCW'(QW - 1);
      q_r    <= '0;
    end
    if (cmd.rdiv_step) begin
      if (rge) rrem_r <= rrem_r - rsh_r;
      rsh_r  <= rsh_r >> 1;
      q_r    <= {q_r[QW-2:0], rge};
      qcnt_r <= qcnt_r - 1'b1;
    end
    if (cmd.rfin) lvl_r <= rsum[LW-1:0];
    if (cmd.load_out) begin
      out_level        <= lvl_r;
      out_digital_out  <= dig_r;
      out_pulse_window <= pwin_r;
      out_train_window <= twin_r;
      out_all_done     <= done_r;
    end
  end

endmodule

// ----- rtl/sptg_checker.sv -----
// Port-level checks for the pulse train generator, bound to the top level.
// Depends only on the top level's ports.
module sptg_checker #(
  parameter int LEVEL_BITS = 16
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [LEVEL_BITS-1:0] out_level,
  input logic                  out_digital_out,
  input logic                  out_pulse_window
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // one tick in flight: busy straight after a transfer in
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second tick taken while busy");

  // first phase lies inside the pulse window
  a_dig_win: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_digital_out |-> out_pulse_window)
    else $error("digital bit outside pulse window");

  // a non-zero level only comes from a pulse
  a_lvl_win: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_level != '0) |-> out_pulse_window)
    else $error("level outside pulse window");

endmodule

bind stimulus_pulse_train_generator sptg_checker #(.LEVEL_BITS(LEVEL_BITS)) u_sptg_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_level        (out_level),
  .out_digital_out  (out_digital_out),
  .out_pulse_window (out_pulse_window)
);

// ----- tb/tb_stimulus_pulse_train_generator.sv -----
// Self-checking testbench for stimulus_pulse_train_generator: sample ticks in,
// one stimulus sample out per tick, checked against an in-bench predictor.
// Depends on sptg_pkg and the RTL top level only.
module tb_stimulus_pulse_train_generator;
  timeunit 1ns;
  timeprecision 1ps;
  import sptg_pkg::*;

  localparam int TIME_BITS  = 24;
  localparam int LEVEL_BITS = 16;
  localparam int COUNT_BITS = 8;
  localparam int ITEMS      = 1700;
  // The limit allows for the worst tick (255 trains, ramp pulse) plus receiver stalls.
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic signed [LEVEL_BITS-1:0] level;
    logic                         digital;
    logic                         pwin;
    logic                         twin;
    logic                         done;
  } sample_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_restart = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic signed [LEVEL_BITS-1:0] out_level;
  logic        out_digital_out, out_pulse_window, out_train_window, out_all_done;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [4:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  always #2 clk = ~clk;

  stimulus_pulse_train_generator dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_restart(in_restart),
    .out_valid(out_valid), .out_ready(out_ready), .out_level(out_level),
    .out_digital_out(out_digital_out), .out_pulse_window(out_pulse_window),
    .out_train_window(out_train_window), .out_all_done(out_all_done),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  // Predictor copy of the register file and sample counter
  logic [TIME_BITS-1:0]         m_delay, m_tperiod, m_pperiod, m_len1, m_len2;
  logic signed [LEVEL_BITS-1:0] m_lvl1, m_lvl2;
  logic [2*COUNT_BITS+1:0]      m_ctrl;
  logic [31:0]                  m_sample;

  sample_t expected_samples[$];
  int      errors = 0;
  int      sent = 0;
  int      tx_idle_pct = 0;
  int      rx_idle_pct = 0;
  int      stall_cycles = 0;
  // Typed expectation for a directed row, used in place of the predictor
  bit      pinned = 1'b0;
  sample_t pinned_val;

  // Works out one sample and advances the counter, as the block should.
  function automatic sample_t stim_sample(input bit restart);
    sample_t r;
    longint unsigned t, np, nt, lfull, lwin, tdur, last, s0, d, p, off, ds, mag, q;
    longint a, b, num, k;
    bit found, bip;
    ptype_t kind;
    r = '0;
    r.done = 1'b1;
    found = 1'b0;
    if (restart) m_sample = '0;
    t = m_sample;
    np = m_ctrl[COUNT_BITS-1:0];
    nt = m_ctrl[2*COUNT_BITS-1:COUNT_BITS];
    kind = ptype_t'(m_ctrl[2*COUNT_BITS+1:2*COUNT_BITS]);
    bip = (kind == PTYPE_BIPHASIC);
    lfull = m_len1 + (bip ? longint'(m_len2) : 0);
    lwin = (lfull != 0) ? lfull : 1;
    if (np != 0 && nt != 0) begin
      tdur = (np - 1) * m_pperiod + lfull;
      last = m_delay + (nt - 1) * m_tperiod + (np - 1) * m_pperiod;
      r.done = (t >= last + lwin);
      // later trains win, so walk from the highest down
      for (k = nt - 1; k >= 0; k--) begin
        s0 = m_delay + longint'(k) * m_tperiod;
        if (t < s0) continue;
        d = t - s0;
        if (d < tdur) r.twin = 1'b1;
        p = np - 1;
        if (m_pperiod != 0 && d / m_pperiod < p) p = d / m_pperiod;
        off = d - p * m_pperiod;
        if (off < m_len1) r.digital = 1'b1;
        if (off < lwin) r.pwin = 1'b1;
        if (!found && off < lfull) begin
          found = 1'b1;
          a = m_lvl1;
          b = m_lvl2;
          if (kind == PTYPE_RAMP) begin
            ds = (m_len1 > 2) ? m_len1 - 1 : 1;
            num = (b - a) * longint'(off);
            mag = (num < 0) ? -num : num;
            q = (mag + ds / 2) / ds;   // half away from zero
            r.level = (num < 0) ? LEVEL_BITS'(a - longint'(q))
                                : LEVEL_BITS'(a + longint'(q));
          end else begin
            r.level = (off < m_len1) ? m_lvl1 : m_lvl2;
          end
        end
      end
    end
    if (m_sample != '1) m_sample++;
    return r;
  endfunction

  // Input side: predict on every accepted tick transfer
  // Output side: compare every result transfer with the oldest expectation
  always @(posedge clk) begin
    sample_t e, got, pred;
    if (in_valid && in_ready) begin
      pred = stim_sample(in_restart);
      expected_samples.push_back(pinned ? pinned_val : pred);
    end
    if (out_valid && out_ready) begin
      got = '{out_level, out_digital_out, out_pulse_window, out_train_window,
              out_all_done};
      if (expected_samples.size() == 0) begin
        $display("%0t: unexpected result, got %h", $time, got);
        errors++;
      end else begin
        e = expected_samples.pop_front();
        if (got.level !== e.level)
          $display("%0t: level expected %0d actual %0d", $time, e.level, got.level);
        if (got.digital !== e.digital)
          $display("%0t: digital_out expected %b actual %b", $time, e.digital, got.digital);
        if (got.pwin !== e.pwin)
          $display("%0t: pulse_window expected %b actual %b", $time, e.pwin, got.pwin);
        if (got.twin !== e.twin)
          $display("%0t: train_window expected %b actual %b", $time, e.twin, got.twin);
        if (got.done !== e.done)
          $display("%0t: all_done expected %b actual %b", $time, e.done, got.done);
        if (got !== e) errors++;
      end
    end
  end

  // Receiver stalls at random per cycle
  always @(posedge clk)
    out_ready <= ($urandom_range(99) >= rx_idle_pct);

  // Watchdog: no transfer on either channel for too long ends the run
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // APB write: setup then access; register lands at the access edge.
  // The bus is left selected so the next write follows straight on.
  task automatic reg_write(input reg_idx_t idx, input logic [31:0] val);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    case (idx)
      REG_START_DELAY:  m_delay   = val[TIME_BITS-1:0];
      REG_TRAIN_PERIOD: m_tperiod = val[TIME_BITS-1:0];
      REG_PULSE_PERIOD: m_pperiod = val[TIME_BITS-1:0];
      REG_FIRST_LEN:    m_len1    = val[TIME_BITS-1:0];
      REG_SECOND_LEN:   m_len2    = val[TIME_BITS-1:0];
      REG_FIRST_LEVEL:  m_lvl1    = val[LEVEL_BITS-1:0];
      REG_SECOND_LEVEL: m_lvl2    = val[LEVEL_BITS-1:0];
      REG_TRAIN_CTRL:   m_ctrl    = val[2*COUNT_BITS+1:0];
      default: ;
    endcase
  endtask

  task automatic load_setting(input logic [31:0] v[8]);
    for (int i = 0; i < 8; i++) reg_write(reg_idx_t'(i), v[i]);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // One tick transfer, with an optional sender gap in front of it
  task automatic send_tick(input bit restart);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_valid <= 1'b1;
    in_restart <= restart;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  // Lets the block settle so the registers can be rewritten
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic logic [31:0] ctrl_word(ptype_t kind, int trains, int pulses);
    return {14'd0, kind, trains[7:0], pulses[7:0]};
  endfunction

  // Directed rows right after reset: no pulses set up, so quiet and done
  typedef struct {
    bit      restart;
    sample_t want;
  } row_t;
  row_t reset_rows[4] = '{
    '{1'b0, '{16'sd0, 1'b0, 1'b0, 1'b0, 1'b1}},
    '{1'b1, '{16'sd0, 1'b0, 1'b0, 1'b0, 1'b1}},
    '{1'b0, '{16'sd0, 1'b0, 1'b0, 1'b0, 1'b1}},
    '{1'b0, '{16'sd0, 1'b0, 1'b0, 1'b0, 1'b1}}
  };

  // Directed settings, one per pulse type, five ticks each from restart
  logic [31:0] type_cfg[4][8];

  initial begin
    logic [31:0] v[8];
    int n, nt, np;
    m_delay = '0; m_tperiod = '0; m_pperiod = '0; m_len1 = '0; m_len2 = '0;
    m_lvl1 = '0; m_lvl2 = '0; m_ctrl = '0; m_sample = '0;
    // TTL, two pulses, full positive level
    type_cfg[0] = '{0, 5, 2, 1, 0, 32'h7FFF, 0, ctrl_word(PTYPE_TTL, 1, 2)};
    // square, pulses all at one instant (zero pulse period), negative extreme
    type_cfg[1] = '{1, 4, 0, 2, 0, 32'h8000, 0, ctrl_word(PTYPE_SQUARE, 2, 3)};
    // biphasic with overlapping trains, later train wins
    type_cfg[2] = '{0, 2, 3, 2, 1, 100, 32'hFF9C, ctrl_word(PTYPE_BIPHASIC, 2, 2)};
    // ramp from bottom to top extreme
    type_cfg[3] = '{0, 0, 0, 5, 0, 32'h8000, 32'h7FFF, ctrl_word(PTYPE_RAMP, 1, 1)};

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (reset_rows[i]) begin
      pinned_val = reset_rows[i].want;
      pinned = 1'b1;
      send_tick(reset_rows[i].restart);
    end
    drain;
    pinned = 1'b0;

    foreach (type_cfg[i]) begin
      load_setting(type_cfg[i]);
      for (int j = 0; j < 5; j++) send_tick(j == 0);
      drain;
    end

    // Random part; phase 0 is every register at its top, phase 1 all zero
    for (int ph = 0; sent < ITEMS; ph++) begin
      if (sent < ITEMS / 3) begin
        tx_idle_pct = 17; rx_idle_pct = 46;
      end else if (sent < 2 * ITEMS / 3) begin
        tx_idle_pct = 46; rx_idle_pct = 17;
      end else begin
        tx_idle_pct = 0; rx_idle_pct = 0;
      end
      if (ph == 0) begin
        v = '{default: 32'hFFFF_FFFF};
      end else if (ph == 1) begin
        v = '{default: 32'h0};
      end else begin
        nt = ($urandom_range(19) == 0) ? 255 : $urandom_range(4);
        np = ($urandom_range(19) == 0) ? 255 : $urandom_range(6);
        for (int i = 0; i < 5; i++) v[i] = $urandom_range(12);
        v[REG_START_DELAY] = $urandom_range(20);
        v[REG_TRAIN_PERIOD] = $urandom_range(40);
        // junk above the register widths must be ignored
        if ($urandom_range(3) == 0)
          for (int i = 0; i < 5; i++) v[i] |= $urandom() & 32'hFF00_0000;
        v[REG_FIRST_LEVEL] = $urandom();
        v[REG_SECOND_LEVEL] = $urandom();
        v[REG_TRAIN_CTRL] = {14'($urandom_range(16383)), 2'($urandom_range(3)),
                             nt[7:0], np[7:0]};
      end
      load_setting(v);
      // long train counts make every tick slow, so keep those phases short
      n = (v[REG_TRAIN_CTRL][15:8] > 16) ? 8 : $urandom_range(40, 90);
      for (int j = 0; j < n; j++)
        send_tick(j == 0 || $urandom_range(24) == 0);
      drain;
    end

    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/sptg_pkg.sv
rtl/sptg_ctrl.sv
rtl/sptg_dp.sv
rtl/stimulus_pulse_train_generator.sv
rtl/sptg_checker.sv
tb/tb_stimulus_pulse_train_generator.sv
